@@ rtl/core/sba_pkg.sv @@
`default_nettype none

package sba_pkg;

   // fixed field widths
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned STATE_W = 10;
   localparam int unsigned MASK_W  = 64;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned BIT_W   = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [STATE_W-1:0]   state_index;
      logic [MASK_W-1:0]    value;
      logic [POS_W-1:0]     list_position;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0]   out_state;
      logic [MASK_W-1:0]    out_mask;
      logic                 newly_touched;
      logic [COUNT_W-1:0]   touched_count;
   } rsp_type;

   // what the datapath does in the current cycle
   typedef enum logic [2:0] {
      PH_NONE,
      PH_INIT,
      PH_ACCEPT,
      PH_ADD,
      PH_RD_LIST,
      PH_CLR
   } phase_type;

   // which response the datapath registers
   typedef enum logic [1:0] {
      EMIT_ADD,
      EMIT_OOR,
      EMIT_READ,
      EMIT_ZERO
   } emit_kind_type;

   typedef struct packed {
      phase_type      phase;
      logic           emit;
      emit_kind_type  emit_kind;
      logic           clear_count;
   } cmd_type;

   typedef struct packed {
      mode_type  req_mode;
      logic      init_done;
      logic      st_ok;
      logic      pos_ok;
      logic      walk_done;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/sba_ram.sv @@
`default_nettype none

module sba_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/core/sba_ctrl.sv @@
`default_nettype none

module sba_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire sba_pkg::status_type status,
   output      sba_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD,
      ST_RD_LIST,
      ST_RD_MASK,
      ST_CLR,
      ST_NOP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath commands
   always_comb begin
      state_in          = state_ff;
      cmd.phase         = sba_pkg::PH_NONE;
      cmd.emit          = 1'b0;
      cmd.emit_kind     = sba_pkg::EMIT_ZERO;
      cmd.clear_count   = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.phase = sba_pkg::PH_INIT;
            if (status.init_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.phase = sba_pkg::PH_ACCEPT;
               unique case (status.req_mode)
                  sba_pkg::MODE_ADD:   state_in = ST_ADD;
                  sba_pkg::MODE_READ:  state_in = ST_RD_LIST;
                  sba_pkg::MODE_CLEAR: state_in = ST_CLR;
                  sba_pkg::MODE_NOP:   state_in = ST_NOP;
                  default:             state_in = ST_NOP;
               endcase
            end
         end
         ST_ADD: begin
            cmd.phase     = sba_pkg::PH_ADD;
            cmd.emit      = 1'b1;
            cmd.emit_kind = status.st_ok ? sba_pkg::EMIT_ADD : sba_pkg::EMIT_OOR;
            state_in      = ST_IDLE;
         end
         ST_RD_LIST: begin
            if (status.pos_ok) begin
               cmd.phase = sba_pkg::PH_RD_LIST;
               state_in  = ST_RD_MASK;
            end else begin
               cmd.emit  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_RD_MASK: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = sba_pkg::EMIT_READ;
            state_in      = ST_IDLE;
         end
         ST_CLR: begin
            cmd.phase = sba_pkg::PH_CLR;
            if (status.walk_done) begin
               cmd.emit        = 1'b1;
               cmd.clear_count = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_NOP: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/sba_dpath.sv @@
`default_nettype none

module sba_dpath #(
   parameter int unsigned NUM_STATES = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sba_pkg::req_type    req_payload,
   input  wire sba_pkg::cmd_type    cmd,
   output      sba_pkg::status_type status,
   output      logic                rsp_strobe,
   output      sba_pkg::rsp_type    rsp_payload
);

   localparam int unsigned AW    = $clog2(NUM_STATES);
   localparam int unsigned CNT_W = $clog2(NUM_STATES + 1);

   sba_pkg::req_type          req_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          walk_ff;
   logic [CNT_W-1:0]          walk_in;
   logic                      pipe_ff;
   logic                      pipe_in;
   logic [AW-1:0]             init_ff;
   logic [AW-1:0]             init_in;
   logic                      rsp_valid_ff;
   sba_pkg::rsp_type          rsp_ff;
   sba_pkg::rsp_type          rsp_in;

   logic                         mask_we;
   logic [AW-1:0]                mask_waddr;
   logic [sba_pkg::MASK_W-1:0]   mask_wdata;
   logic                         mask_re;
   logic [AW-1:0]                mask_raddr;
   logic [sba_pkg::MASK_W-1:0]   mask_rdata;
   logic                         list_we;
   logic [AW-1:0]                list_waddr;
   logic [sba_pkg::STATE_W-1:0]  list_wdata;
   logic                         list_re;
   logic [AW-1:0]                list_raddr;
   logic [sba_pkg::STATE_W-1:0]  list_rdata;

   logic [sba_pkg::MASK_W-1:0]   new_mask;
   logic                         is_fresh;
   logic                         walk_more;
   logic                         list_room;

   sba_ram #(
      .WIDTH (sba_pkg::MASK_W),
      .DEPTH (NUM_STATES)
   ) u_mask_ram (
      .clock (clock),
      .we    (mask_we),
      .waddr (mask_waddr),
      .wdata (mask_wdata),
      .re    (mask_re),
      .raddr (mask_raddr),
      .rdata (mask_rdata)
   );

   sba_ram #(
      .WIDTH (sba_pkg::STATE_W),
      .DEPTH (NUM_STATES)
   ) u_list_ram (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .re    (list_re),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   // status toward the controller
   assign new_mask  = mask_rdata | (sba_pkg::MASK_W'(1) << req_ff.value[sba_pkg::BIT_W-1:0]);
   assign is_fresh  = (mask_rdata == '0);
   assign walk_more = (walk_ff < count_ff);
   assign list_room = (32'(count_ff) < NUM_STATES);

   assign status.req_mode  = req_payload.mode;
   assign status.init_done = (init_ff == AW'(NUM_STATES - 1));
   assign status.st_ok     = (32'(req_ff.state_index) < NUM_STATES);
   assign status.pos_ok    = (32'(req_ff.list_position) < 32'(count_ff));
   assign status.walk_done = !walk_more && !pipe_ff;

   // memory controls and counters per phase
   always_comb begin
      mask_we    = 1'b0;
      mask_waddr = AW'(req_ff.state_index);
      mask_wdata = '0;
      mask_re    = 1'b0;
      mask_raddr = AW'(req_payload.state_index);
      list_we    = 1'b0;
      list_waddr = count_ff[AW-1:0];
      list_wdata = req_ff.state_index;
      list_re    = 1'b0;
      list_raddr = AW'(req_payload.list_position);
      count_in   = count_ff;
      walk_in    = walk_ff;
      pipe_in    = pipe_ff;
      init_in    = init_ff;
      unique case (cmd.phase)
         sba_pkg::PH_NONE: begin
         end
         sba_pkg::PH_INIT: begin
            mask_we    = 1'b1;
            mask_waddr = init_ff;
            init_in    = init_ff + AW'(1);
         end
         sba_pkg::PH_ACCEPT: begin
            mask_re = 1'b1;
            list_re = 1'b1;
            walk_in = '0;
            pipe_in = 1'b0;
         end
         sba_pkg::PH_ADD: begin
            if (status.st_ok) begin
               mask_we    = 1'b1;
               mask_wdata = new_mask;
               if (is_fresh && list_room) begin
                  list_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         sba_pkg::PH_RD_LIST: begin
            mask_re    = 1'b1;
            mask_raddr = AW'(list_rdata);
         end
         sba_pkg::PH_CLR: begin
            // list read one step ahead of the mask wipe
            list_raddr = walk_ff[AW-1:0];
            if (walk_more) begin
               list_re = 1'b1;
               walk_in = walk_ff + CNT_W'(1);
            end
            pipe_in = walk_more;
            if (pipe_ff) begin
               mask_we    = 1'b1;
               mask_waddr = AW'(list_rdata);
            end
         end
         default: begin
         end
      endcase
      if (cmd.clear_count) begin
         count_in = '0;
      end
   end

   // response formation
   always_comb begin
      rsp_in = '0;
      unique case (cmd.emit_kind)
         sba_pkg::EMIT_ADD: begin
            rsp_in.out_state     = req_ff.state_index;
            rsp_in.out_mask      = new_mask;
            rsp_in.newly_touched = is_fresh;
         end
         sba_pkg::EMIT_OOR: begin
            rsp_in.out_state = req_ff.state_index;
         end
         sba_pkg::EMIT_READ: begin
            rsp_in.out_state = list_rdata;
            rsp_in.out_mask  = mask_rdata;
         end
         sba_pkg::EMIT_ZERO: begin
         end
         default: begin
         end
      endcase
      rsp_in.touched_count = sba_pkg::COUNT_W'(count_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         walk_ff      <= '0;
         pipe_ff      <= 1'b0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         pipe_ff      <= pipe_in;
         init_ff      <= init_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.phase == sba_pkg::PH_ACCEPT) begin
         req_ff <= req_payload;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/sparse_bitset_accumulator.sv @@
// channel    ports                      handshake
// request    start, busy, req_payload   taken when start high and busy low
// response   rsp_strobe, rsp_payload    one cycle per transaction, no back-pressure
//
// add: mask word read, then update and list append
// read: list read, then mask read; a position past the count skips the mask read
// clear: the touched list is walked, one list entry wiped per cycle
// unused mode: the response strobes in the same cycle that busy drops
// after reset every word of the mask store is swept to zero with busy high
`default_nettype none

module sparse_bitset_accumulator #(
   parameter int unsigned NUM_STATES = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire sba_pkg::req_type req_payload,
   output      logic             rsp_strobe,
   output      sba_pkg::rsp_type rsp_payload
);

   sba_pkg::cmd_type    cmd;
   sba_pkg::status_type status;

   // sequencing
   sba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // mask store, touched list and response register
   sba_dpath #(
      .NUM_STATES (NUM_STATES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ dv/sparse_bitset_accumulator_tb.sv @@
`default_nettype none

module sparse_bitset_accumulator_tb;

   localparam int NUM_STATES   = 1024;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 630;
   localparam int DRAIN_CYCLES = 40;
   localparam int SHOWN_ERRORS = 10;
   // init sweep or a full clear walk, plus the longest sender gap, with margin
   localparam int IDLE_LIMIT   = 8 * (NUM_STATES + 16);
   localparam int HOT_SIZE     = 16;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sba_pkg::req_type req_payload = '0;
   logic             rsp_strobe;
   sba_pkg::rsp_type rsp_payload;

   // shadow copy of the accumulator state
   logic [sba_pkg::MASK_W-1:0]  mask_shadow [NUM_STATES];
   logic [sba_pkg::STATE_W-1:0] touched_shadow [NUM_STATES];
   logic [sba_pkg::COUNT_W-1:0] touched_total_shadow;

   sba_pkg::rsp_type expected_rsp_q [$];

   int mismatch_count = 0;
   int responses_checked = 0;
   int add_count = 0, read_count = 0, clear_count = 0, nop_count = 0;
   int peak_touched = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit gaps_enabled = 1'b1;
   logic [sba_pkg::STATE_W-1:0] hot_states [HOT_SIZE];

   sparse_bitset_accumulator #(
      .NUM_STATES(NUM_STATES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // expected response for one accepted transaction, state updated in place
   function automatic sba_pkg::rsp_type apply_transaction(input sba_pkg::req_type r);
      sba_pkg::rsp_type            rsp;
      logic [sba_pkg::STATE_W-1:0] listed;
      rsp = '0;
      case (r.mode)
         sba_pkg::MODE_ADD: begin
            rsp.out_state = r.state_index;
            if (r.state_index < NUM_STATES) begin
               if (mask_shadow[r.state_index] == '0) begin
                  if (touched_total_shadow < NUM_STATES) begin
                     touched_shadow[touched_total_shadow] = r.state_index;
                     touched_total_shadow = touched_total_shadow + 1'b1;
                  end
                  rsp.newly_touched = 1'b1;
               end
               mask_shadow[r.state_index] =
                  mask_shadow[r.state_index] | (64'd1 << r.value[sba_pkg::BIT_W-1:0]);
               rsp.out_mask = mask_shadow[r.state_index];
            end
         end
         sba_pkg::MODE_READ: begin
            if (r.list_position < touched_total_shadow) begin
               listed = touched_shadow[r.list_position];
               rsp.out_state = listed;
               rsp.out_mask  = mask_shadow[listed];
            end
         end
         sba_pkg::MODE_CLEAR: begin
            for (int i = 0; i < touched_total_shadow; i++)
               mask_shadow[touched_shadow[i]] = '0;
            touched_total_shadow = '0;
         end
         default: begin
         end
      endcase
      rsp.touched_count = touched_total_shadow;
      if (touched_total_shadow > peak_touched)
         peak_touched = int'(touched_total_shadow);
      return rsp;
   endfunction

   function automatic sba_pkg::req_type make_req(input sba_pkg::mode_type m,
                                                 input logic [sba_pkg::STATE_W-1:0] st,
                                                 input logic [sba_pkg::MASK_W-1:0] v,
                                                 input logic [sba_pkg::POS_W-1:0] pos);
      sba_pkg::req_type r;
      r.mode          = m;
      r.state_index   = st;
      r.value         = v;
      r.list_position = pos;
      return r;
   endfunction

   function automatic void reroll_hot_states();
      for (int i = 0; i < HOT_SIZE; i++)
         hot_states[i] = sba_pkg::STATE_W'($urandom);
   endfunction

   // sender pacing: random bursts, random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = gaps_enabled ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // drive one transaction at a falling edge, wait for it to be taken
   task automatic send_transaction(input sba_pkg::req_type r);
      sba_pkg::rsp_type exp_rsp;
      start       = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      exp_rsp = apply_transaction(r);
      expected_rsp_q.insert(expected_rsp_q.size(), exp_rsp);
      case (r.mode)
         sba_pkg::MODE_ADD:   add_count++;
         sba_pkg::MODE_READ:  read_count++;
         sba_pkg::MODE_CLEAR: clear_count++;
         default:             nop_count++;
      endcase
      @(negedge clock);
      pace_sender();
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] exp_val,
                                  input logic [63:0] act_val);
      if (mismatch_count < SHOWN_ERRORS)
         $display("tb: %s mismatch at %0t: expected %h, got %h",
                  field, $realtime, exp_val, act_val);
      mismatch_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      sba_pkg::rsp_type exp;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            if (mismatch_count < SHOWN_ERRORS)
               $display("tb: response with no transaction outstanding at %0t: %p",
                        $realtime, rsp_payload);
            mismatch_count++;
         end else begin
            exp = expected_rsp_q.pop_front();
            responses_checked++;
            if (rsp_payload.out_state !== exp.out_state)
               report_mismatch("out_state", 64'(exp.out_state),
                               64'(rsp_payload.out_state));
            if (rsp_payload.out_mask !== exp.out_mask)
               report_mismatch("out_mask", exp.out_mask, rsp_payload.out_mask);
            if (rsp_payload.newly_touched !== exp.newly_touched)
               report_mismatch("newly_touched", 64'(exp.newly_touched),
                               64'(rsp_payload.newly_touched));
            if (rsp_payload.touched_count !== exp.touched_count)
               report_mismatch("touched_count", 64'(exp.touched_count),
                               64'(rsp_payload.touched_count));
         end
      end
   end

   // watchdog on cycles with no transaction taken or returned
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: no progress for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // reads, unused mode and clear on an empty list
   task automatic test_empty_list();
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'h3FF, '1, 10'h3FF));
      send_transaction(make_req(sba_pkg::MODE_NOP, 10'h3FF, '1, 10'h3FF));
      send_transaction(make_req(sba_pkg::MODE_CLEAR, 10'h3FF, '1, 10'h3FF));
   endtask

   // adds at the extremes of state and bit index, repeat hits on one state
   task automatic test_add_extremes();
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'd0, 64'd0, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'h3FF, '1, 10'h3FF));
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'd0, 64'd64, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'd0, 64'd63, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'd512, 64'h8000_0000_0000_0020,
                                10'd0));
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'h3FF, 64'd1, 10'd0));
   endtask

   // reads inside the list, just past its end and at the top position
   task automatic test_list_reads();
      send_transaction(make_req(sba_pkg::MODE_READ, 10'h3FF, '1, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'd1));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'd2));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'd3));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'h3FF));
      send_transaction(make_req(sba_pkg::MODE_NOP, 10'd0, '0, 10'd0));
   endtask

   // clear, then a state that was cleared is touched anew
   task automatic test_clear_and_retouch();
      send_transaction(make_req(sba_pkg::MODE_CLEAR, 10'd0, '0, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_ADD, 10'h3FF, 64'd5, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_READ, 10'd0, '0, 10'd0));
      send_transaction(make_req(sba_pkg::MODE_CLEAR, 10'd0, '0, 10'd0));
   endtask

   // mostly adds to a small hot set and reads inside the list, some noise
   task automatic test_random_traffic();
      sba_pkg::req_type r;
      int               sel;
      reroll_hot_states();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0)
            gaps_enabled = ($urandom_range(0, 3) != 0);
         sel             = $urandom_range(0, 99);
         r.value         = {$urandom, $urandom};
         r.state_index   = sba_pkg::STATE_W'($urandom);
         r.list_position = sba_pkg::POS_W'($urandom);
         if (sel < 60) begin
            r.mode = sba_pkg::MODE_ADD;
            if ($urandom_range(0, 9) < 7)
               r.state_index = hot_states[$urandom_range(0, HOT_SIZE - 1)];
         end else if (sel < 90) begin
            r.mode = sba_pkg::MODE_READ;
            if (touched_total_shadow > 0 && $urandom_range(0, 9) < 8)
               r.list_position =
                  sba_pkg::POS_W'($urandom_range(0, touched_total_shadow - 1));
         end else if (sel < 95) begin
            r.mode = sba_pkg::MODE_CLEAR;
            reroll_hot_states();
         end else begin
            r.mode = sba_pkg::MODE_NOP;
         end
         send_transaction(r);
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_STATES; i++) begin
         mask_shadow[i]    = '0;
         touched_shadow[i] = '0;
      end
      touched_total_shadow = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_add_extremes();
      test_list_reads();
      test_clear_and_retouch();
      test_random_traffic();

      start = 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d transactions sent (%0d add, %0d read, %0d clear, %0d unused mode)",
               add_count + read_count + clear_count + nop_count,
               add_count, read_count, clear_count, nop_count);
      $display("tb: %0d responses checked, peak touched count %0d, %0d mismatches",
               responses_checked, peak_touched, mismatch_count);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
